[rtl/core/psg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psg_pkg
// shared constants and types for the sound generator core
// ----------------------------------------------------------------------------
package psg_pkg;

  localparam int unsigned NumRegs  = 16;
  localparam int unsigned NumTones = 3;
  localparam logic [16:0] LfsrTap  = 17'h12000;  // 0x24000 >> 1, applied after shift

  localparam logic [3:0] RegMixer    = 4'd7;
  localparam logic [3:0] RegNoise    = 4'd6;
  localparam logic [3:0] RegEnvFine  = 4'd11;
  localparam logic [3:0] RegEnvCoarse = 4'd12;
  localparam logic [3:0] RegEnvShape = 4'd13;
  localparam logic [3:0] RegToneLast = 4'd5;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdTick  = 1'b1;

  // request to the shared modulo unit
  typedef struct packed {
    logic        start;
    logic [13:0] dividend;
    logic [13:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [13:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

[rtl/core/psg_mod_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psg_mod_unit
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psg_mod_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire psg_pkg::mod_req_t req,
  output psg_pkg::mod_rsp_t     rsp
);

  logic        busy;
  logic        done_pulse;
  logic [3:0]  bit_idx;
  logic [13:0] rem;
  logic [13:0] divisor;
  logic [13:0] dividend;
  logic [14:0] trial;

  assign trial = {rem, dividend[bit_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done_pulse <= 1'b0;
    end else begin
      done_pulse <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        bit_idx  <= 4'd13;
        rem      <= '0;
        divisor  <= req.divisor;
        dividend <= req.dividend;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= 14'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[13:0];
        end
        if (bit_idx == 4'd0) begin
          busy       <= 1'b0;
          done_pulse <= 1'b1;
        end else begin
          bit_idx <= bit_idx - 4'd1;
        end
      end
    end
  end

  // final remainder is presented in the cycle after the last step
  assign rsp = '{done: done_pulse, rem: rem};

endmodule
`default_nettype wire

[rtl/core/psg_tone_noise_envelope.sv]
`timescale 1ns / 1ps
`default_nettype none
// a write is taken in S_IDLE; one to a tone period register that leaves its counter
// too large waits in S_WMOD for the shared remainder unit to reduce it
// a tick runs S_ENV, then S_TONE and S_TMOD per channel, then S_NOISE and S_OUT;
// a wrapping channel waits in S_TMOD for the shared remainder unit; one transaction
// at a time; a tick waits in S_OUT while the result register is stalled
// reset: synchronous, clears registers and counters, tone periods become one
// ----------------------------------------------------------------------------
// psg_tone_noise_envelope
// three-channel tone, noise and envelope generator, volume index outputs
// ----------------------------------------------------------------------------
module psg_tone_noise_envelope (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic       cmd,
  input  wire logic [3:0] reg_addr,
  input  wire logic [7:0] reg_data,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [3:0] level_a,
  output      logic       on_a,
  output      logic [3:0] level_b,
  output      logic       on_b,
  output      logic [3:0] level_c,
  output      logic       on_c
);

  typedef enum logic [2:0] {
    S_IDLE, S_WMOD, S_ENV, S_TONE, S_TMOD, S_NOISE, S_OUT
  } state_t;

  state_t state;
  logic [7:0]  regs [psg_pkg::NumRegs];
  logic [11:0] tone_period [psg_pkg::NumTones];
  logic [12:0] tone_count  [psg_pkg::NumTones];
  logic [2:0]  tone_phase;
  logic [4:0]  noise_period;
  logic [5:0]  noise_cnt;
  logic        noise_flip;
  logic [16:0] lfsr;
  logic [15:0] env_count;
  logic [3:0]  env_step;
  logic [3:0]  env_value;
  logic        env_first;
  logic        env_rev;

  logic [1:0]  ch;
  logic        noise_now;
  logic [3:0]  lvl [psg_pkg::NumTones];
  logic [2:0]  on_bits;
  logic [12:0] cnt_tmp;
  logic        mod_wait;

  psg_pkg::mod_req_t mreq;
  psg_pkg::mod_rsp_t mrsp;

  psg_mod_unit u_mod (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));

  logic        accept;
  logic [15:0] env_period;
  logic [11:0] new_period;
  logic [1:0]  wch;
  logic [12:0] cnt_inc;
  logic [15:0] env_inc;
  logic        env_fire;
  logic [5:0]  noise_inc;
  logic        noise_fire;
  logic [3:0]  env_val_mv;
  logic [3:0]  env_val_fire;
  logic [3:0]  env_step_n;
  logic        out_free;
  logic        cont, attack, alt, hold;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign env_period = {regs[psg_pkg::RegEnvCoarse], regs[psg_pkg::RegEnvFine]};
  assign cont   = regs[psg_pkg::RegEnvShape][3];
  assign attack = regs[psg_pkg::RegEnvShape][2];
  assign alt    = regs[psg_pkg::RegEnvShape][1];
  assign hold   = regs[psg_pkg::RegEnvShape][0];
  assign wch    = reg_addr[2:1];
  assign cnt_inc = tone_count[ch] + 13'd2;
  assign env_inc = env_count + 16'd1;
  assign noise_inc = noise_cnt + 6'd1;
  assign env_fire  = (env_period == 16'd0) || (env_inc >= env_period);
  assign noise_fire = (noise_period == 5'd0) || (noise_inc >= {1'b0, noise_period});
  assign env_step_n = env_step + 4'd1;

  always_comb begin
    env_val_mv = env_value;
    if (env_first || (cont && !hold)) begin
      if (attack ^ env_rev) begin
        if (env_value != 4'd15) env_val_mv = env_value + 4'd1;
      end else begin
        if (env_value != 4'd0) env_val_mv = env_value - 4'd1;
      end
    end
  end

  // value after a fire, including the end-of-cycle shape rules
  always_comb begin
    env_val_fire = env_val_mv;
    if (env_step_n == 4'd0) begin
      if (!cont) env_val_fire = 4'd0;
      else if (hold) begin
        if (env_first && alt) env_val_fire = (env_val_mv != 4'd0) ? 4'd0 : 4'd15;
      end else if (!alt) env_val_fire = attack ? 4'd0 : 4'd15;
    end
  end

  always_comb begin
    new_period = {regs[{wch, 1'b1}][3:0], regs[{wch, 1'b0}]};
    if (reg_addr[0]) new_period[11:8] = reg_data[3:0];
    else new_period[7:0] = reg_data;
    if (new_period == 12'd0) new_period = 12'd1;
  end

  always_comb begin
    mreq = '0;
    if (accept && cmd == psg_pkg::CmdWrite && reg_addr <= psg_pkg::RegToneLast) begin
      mreq.start    = ({1'b0, tone_count[wch]} >= {1'b0, new_period, 1'b0});
      mreq.dividend = {1'b0, tone_count[wch]};
      mreq.divisor  = {1'b0, new_period, 1'b0};
    end else if (state == S_TONE && !regs[psg_pkg::RegMixer][ch]) begin
      mreq.start    = (cnt_inc >= {1'b0, tone_period[ch]});
      mreq.dividend = {1'b0, cnt_inc};
      mreq.divisor  = {2'b0, tone_period[ch]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      for (int i = 0; i < 16; i++) regs[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        tone_period[i] <= 12'd1;
        tone_count[i]  <= '0;
      end
      tone_phase   <= '0;
      noise_period <= '0;
      noise_cnt    <= '0;
      noise_flip   <= 1'b0;
      lfsr         <= 17'd1;
      env_count    <= '0;
      env_step     <= '0;
      env_value    <= '0;
      env_first    <= 1'b0;
      env_rev      <= 1'b0;
      ch           <= '0;
      mod_wait     <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == psg_pkg::CmdWrite) begin
              regs[reg_addr] <= reg_data;
              if (reg_addr <= psg_pkg::RegToneLast) begin
                tone_period[wch] <= new_period;
                ch <= wch;
                if (mreq.start) state <= S_WMOD;
              end else if (reg_addr == psg_pkg::RegNoise) begin
                noise_cnt    <= '0;
                noise_period <= reg_data[4:0];
              end else if (reg_addr == psg_pkg::RegEnvShape) begin
                env_first <= 1'b1;
                env_rev   <= 1'b0;
                env_step  <= '0;
                env_count <= '0;
                env_value <= reg_data[2] ? 4'd0 : 4'd15;
              end
            end else begin
              noise_now <= noise_flip;
              for (int i = 0; i < 3; i++) begin
                lvl[i] <= regs[8 + i][4] ? env_value : regs[8 + i][3:0];
              end
              state <= S_ENV;
            end
          end
        end
        S_WMOD: begin
          if (mrsp.done) begin
            tone_count[ch] <= mrsp.rem[12:0];
            state <= S_IDLE;
          end
        end
        S_ENV: begin
          if (env_period != 16'd0) begin
            env_count <= env_fire ? env_inc - env_period : env_inc;
          end
          if (env_fire) begin
            env_value <= env_val_fire;
            env_step  <= env_step_n;
            if (env_step_n == 4'd0) begin
              if (cont && !hold && alt) env_rev <= ~env_rev;
              env_first <= 1'b0;
            end
          end
          ch    <= '0;
          state <= S_TONE;
        end
        S_TONE: begin
          if (regs[psg_pkg::RegMixer][ch]) begin
            on_bits[ch] <= 1'b1;
            state <= S_TMOD;
            mod_wait <= 1'b0;
          end else if (mreq.start) begin
            tone_phase[ch] <= ~tone_phase[ch];
            mod_wait <= 1'b1;
            state <= S_TMOD;
          end else begin
            tone_count[ch] <= cnt_inc;
            on_bits[ch] <= tone_phase[ch];
            mod_wait <= 1'b0;
            state <= S_TMOD;
          end
        end
        S_TMOD: begin
          if (!mod_wait || mrsp.done) begin
            if (mod_wait) begin
              tone_count[ch] <= mrsp.rem[12:0];
              on_bits[ch] <= tone_phase[ch];
            end
            mod_wait <= 1'b0;
            if (ch == 2'd2) state <= S_NOISE;
            else begin
              ch <= ch + 2'd1;
              state <= S_TONE;
            end
          end
        end
        S_NOISE: begin
          if (noise_period != 5'd0) begin
            noise_cnt <= noise_fire ? noise_inc - {1'b0, noise_period} : noise_inc;
          end
          if (noise_fire) begin
            if (lfsr[0] ^ lfsr[1]) noise_flip <= ~noise_flip;
            lfsr <= (lfsr >> 1) ^ (lfsr[0] ? psg_pkg::LfsrTap : 17'd0);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // wait here while the previous result is still stalled
          if (out_free) begin
            level_a <= lvl[0];
            level_b <= lvl[1];
            level_c <= lvl[2];
            on_a <= on_bits[0] && !(!regs[psg_pkg::RegMixer][3] && noise_now);
            on_b <= on_bits[1] && !(!regs[psg_pkg::RegMixer][4] && noise_now);
            on_c <= on_bits[2] && !(!regs[psg_pkg::RegMixer][5] && noise_now);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cnt_tmp = tone_count[0];

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(level_a) && $stable(on_a)))
    else $error("result changed while stalled");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cnt_tmp != 13'd0) |-> (cnt_tmp < {tone_period[0], 1'b0}))
    else $error("tone count out of range");

endmodule
`default_nettype wire

[sim/psg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_checker
// watches all three channels, predicts the volume and on bits of every tick and
// compares them field by field with what the generator delivers
// ----------------------------------------------------------------------------
module psg_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       cmd,
  input  logic [3:0] reg_addr,
  input  logic [7:0] reg_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] level_a,
  input  logic       on_a,
  input  logic [3:0] level_b,
  input  logic       on_b,
  input  logic [3:0] level_c,
  input  logic       on_c,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [3:0] lvl_a;
    logic       snd_a;
    logic [3:0] lvl_b;
    logic       snd_b;
    logic [3:0] lvl_c;
    logic       snd_c;
  } voice_out_t;

  voice_out_t   voice_q[$];
  logic [7:0]   regs[psg_pkg::NumRegs];
  logic [11:0]  t_per[psg_pkg::NumTones];
  logic [12:0]  t_cnt[psg_pkg::NumTones];
  logic         t_ph[psg_pkg::NumTones];
  logic [4:0]   n_per;
  logic [5:0]   n_cnt;
  logic         n_out;
  logic [16:0]  lfsr;
  logic [15:0]  e_per, e_cnt;
  logic [3:0]   e_step, e_val;
  logic         e_first, e_rev;

  assign pending = voice_q.size();

  task automatic clear_state();
    for (int i = 0; i < psg_pkg::NumRegs; i++) regs[i] = '0;
    for (int i = 0; i < psg_pkg::NumTones; i++) begin
      t_per[i] = 12'd1;
      t_cnt[i] = '0;
      t_ph[i] = 1'b0;
    end
    n_per = '0; n_cnt = '0; n_out = 1'b0; lfsr = 17'd1;
    e_per = '0; e_cnt = '0; e_step = '0; e_val = '0; e_first = 1'b0; e_rev = 1'b0;
  endtask

  function automatic void envelope_advance(input logic [7:0] shape);
    logic cont, attack, alt, hold;
    cont = shape[3]; attack = shape[2]; alt = shape[1]; hold = shape[0];
    if (e_first || (cont && !hold)) begin
      if (attack ^ e_rev) begin
        if (e_val != 4'd15) e_val++;
      end else if (e_val != 4'd0) begin
        e_val--;
      end
    end
    e_step = e_step + 4'd1;
    if (e_step == 4'd0) begin
      if (!cont) e_val = 4'd0;
      else if (hold) begin
        if (e_first && alt) e_val = (e_val != 0) ? 4'd0 : 4'd15;
      end else if (alt) e_rev = !e_rev;
      else e_val = attack ? 4'd0 : 4'd15;
      e_first = 1'b0;
    end
  endfunction

  function automatic void noise_advance();
    logic low;
    low = lfsr[0];
    if (lfsr[0] ^ lfsr[1]) n_out = !n_out;
    // the 0x24000 tap lands on bits 16 and 13 once shifted
    lfsr = (lfsr >> 1) ^ (low ? 17'h12000 : 17'h00000);
  endfunction

  task automatic apply_write(input logic [3:0] a, input logic [7:0] d);
    int unsigned t, p;
    regs[a] = d;
    if (a <= psg_pkg::RegToneLast) begin
      t = a >> 1;
      p = regs[2 * t] + 256 * regs[2 * t + 1][3:0];
      if (p == 0) p = 1;
      t_per[t] = p[11:0];
      if (t_cnt[t] >= 2 * p) t_cnt[t] = 13'(t_cnt[t] % (2 * p));
    end else if (a == psg_pkg::RegNoise) begin
      n_cnt = '0;
      n_per = d[4:0];
    end else if (a == psg_pkg::RegEnvFine || a == psg_pkg::RegEnvCoarse) begin
      e_per = {regs[psg_pkg::RegEnvCoarse], regs[psg_pkg::RegEnvFine]};
    end else if (a == psg_pkg::RegEnvShape) begin
      e_first = 1'b1; e_rev = 1'b0; e_step = '0; e_cnt = '0;
      e_val = d[2] ? 4'd0 : 4'd15;
    end
  endtask

  function automatic voice_out_t tick_voices();
    voice_out_t r;
    logic [7:0] mix;
    logic [3:0] lv[psg_pkg::NumTones];
    logic snd[psg_pkg::NumTones];
    logic noise_now;
    int unsigned c;
    mix = regs[psg_pkg::RegMixer];
    noise_now = n_out;
    for (int n = 0; n < psg_pkg::NumTones; n++)
      lv[n] = regs[8 + n][4] ? e_val : regs[8 + n][3:0];
    if (e_per == 0) envelope_advance(regs[psg_pkg::RegEnvShape]);
    else begin
      e_cnt = e_cnt + 16'd1;
      if (e_cnt >= e_per) begin
        e_cnt = e_cnt - e_per;
        envelope_advance(regs[psg_pkg::RegEnvShape]);
      end
    end
    for (int n = 0; n < psg_pkg::NumTones; n++) begin
      snd[n] = 1'b1;
      if (!mix[n]) begin
        c = (t_cnt[n] + 2) & 13'h1fff;
        if (c >= t_per[n]) begin
          c = c % t_per[n];
          t_ph[n] = !t_ph[n];
        end
        t_cnt[n] = c[12:0];
        snd[n] = t_ph[n];
      end
      if (!mix[3 + n] && noise_now) snd[n] = 1'b0;
    end
    if (n_per == 0) noise_advance();
    else begin
      n_cnt = n_cnt + 6'd1;
      if (n_cnt >= {1'b0, n_per}) begin
        n_cnt = n_cnt - {1'b0, n_per};
        noise_advance();
      end
    end
    r = '{lv[0], snd[0], lv[1], snd[1], lv[2], snd[2]};
    return r;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    voice_out_t w;
    if (rst) begin
      clear_state();
      voice_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cmd == psg_pkg::CmdWrite) apply_write(reg_addr, reg_data);
        else voice_q.push_back(tick_voices());
      end
      if (out_valid && !out_stall) begin
        if (voice_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          w = voice_q.pop_front();
          compare_field("level_a", w.lvl_a, level_a);
          compare_field("on_a", w.snd_a, on_a);
          compare_field("level_b", w.lvl_b, level_b);
          compare_field("on_b", w.snd_b, on_b);
          compare_field("level_c", w.lvl_c, level_c);
          compare_field("on_c", w.snd_c, on_c);
        end
      end
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives register writes and ticks into the sound generator under several
// idle and stall mixes; the checker predicts and compares each result
// ----------------------------------------------------------------------------
module tb;

  localparam int StallLimit = 20000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       cmd = psg_pkg::CmdTick;
  logic [3:0] reg_addr = '0;
  logic [7:0] reg_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] level_a, level_b, level_c;
  logic       on_a, on_b, on_c;
  int         fail_count, pending;
  int         idle_pct = 0, stall_pct = 0;
  int         quiet = 0;

  always #4 clk = ~clk;

  psg_tone_noise_envelope i_dut (.*);
  psg_checker i_chk (.*);

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < stall_pct);
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  always @(posedge clk) begin
    if (quiet >= StallLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // one transaction, holding valid until accepted
  task automatic send_item(input logic c, input logic [3:0] a, input logic [7:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    reg_addr <= a;
    reg_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender goes quiet until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [3:0] a, input logic [7:0] d);
    send_item(psg_pkg::CmdWrite, a, d);
  endtask

  task automatic ticks(input int n);
    for (int i = 0; i < n; i++) send_item(psg_pkg::CmdTick, 4'($urandom), 8'($urandom));
  endtask

  // random program with short periods so dividers and envelope move a lot
  task automatic random_burst();
    logic [3:0] a;
    for (int i = 0; i < 6; i++) begin
      a = 4'($urandom_range(15));
      if (a <= psg_pkg::RegToneLast && a[0])
        put_reg(a, $urandom_range(3) == 0 ? 8'($urandom) : 8'h0);
      else if (a <= psg_pkg::RegToneLast || a == psg_pkg::RegEnvFine)
        put_reg(a, $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(6)));
      else if (a == psg_pkg::RegEnvCoarse)
        put_reg(a, $urandom_range(7) == 0 ? 8'($urandom) : 8'h0);
      else put_reg(a, 8'($urandom));
    end
    ticks($urandom_range(5, 20));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, every shape, tone wrap reduction, zero periods
    ticks(2);
    put_reg(4'd0, 8'hff); put_reg(4'd1, 8'hff); ticks(2);
    put_reg(4'd1, 8'h00); put_reg(4'd0, 8'h00); ticks(2);
    put_reg(psg_pkg::RegMixer, 8'h00); put_reg(4'd8, 8'h1f); put_reg(4'd9, 8'h0f);
    put_reg(4'd10, 8'h10); put_reg(psg_pkg::RegNoise, 8'hff); ticks(2);
    put_reg(psg_pkg::RegEnvFine, 8'hff); put_reg(psg_pkg::RegEnvCoarse, 8'hff); ticks(1);
    put_reg(psg_pkg::RegEnvFine, 8'h00); put_reg(psg_pkg::RegEnvCoarse, 8'h00);
    for (int s = 0; s < 16; s++) begin
      put_reg(psg_pkg::RegEnvShape, s[7:0]);
      ticks(s == 15 ? 3 : 0);
    end
    put_reg(psg_pkg::RegMixer, 8'hff); put_reg(4'd15, 8'haa); ticks(1);
    // random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 64 : (ph == 3) ? 18 : 0;
      stall_pct = (ph == 2) ? 64 : (ph == 3) ? 18 : 0;
      for (int k = 0; k < 12; k++) random_burst();
      if (ph == 1) begin
        drain();
        repeat (60) @(posedge clk);
      end
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/psg_pkg.sv
rtl/core/psg_mod_unit.sv
rtl/core/psg_tone_noise_envelope.sv
sim/psg_checker.sv
sim/tb.sv
